// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the servo packet responder
// Protocol codes, table addresses, sequencer states, table access bundle
// and the power-on contents of the register table.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [7:0] INSTR_READ   = 8'h02;
    localparam logic [7:0] INSTR_WRITE  = 8'h03;
    localparam logic [9:0] LIMIT_10BIT  = 10'h3FF;

    localparam logic [7:0] ADDR_ID      = 8'd3;
    localparam logic [7:0] ADDR_GOAL    = 8'd30;
    localparam logic [7:0] ADDR_PRESENT = 8'd36;

    localparam logic CFG_DISCONNECTED = 1'b0;
    localparam logic CFG_STEP_GAIN    = 1'b1;

    localparam logic [31:0] POS_RESET  = 32'h01FF_0000;
    localparam logic [31:0] GAIN_RESET = 32'd24486000;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_EXEC  = 13'b0000000000010,
        ST_WRD   = 13'b0000000000100,
        ST_WWR   = 13'b0000000001000,
        ST_HDR   = 13'b0000000010000,
        ST_DRD   = 13'b0000000100000,
        ST_DOUT  = 13'b0000001000000,
        ST_CHK   = 13'b0000010000000,
        ST_TRD   = 13'b0000100000000,
        ST_TMUL  = 13'b0001000000000,
        ST_TGAIN = 13'b0010000000000,
        ST_TSTEP = 13'b0100000000000,
        ST_TPRES = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] addr;
        logic [7:0] wdata;
    } tbl_req_t;

    function automatic logic [7:0] spr_default(input logic [7:0] addr,
                                               input logic [7:0] id,
                                               input logic [7:0] model);
        logic       m12;
        logic [7:0] v;
        m12 = (model == 8'd12);
        v   = 8'h00;
        unique case (addr)
            8'd0:  v = model;
            8'd3:  v = id;
            8'd4:  v = 8'h01;
            8'd5:  v = 8'hFA;
            8'd8:  v = 8'hFF;
            8'd9:  v = 8'h03;
            8'd11: v = m12 ? 8'h55 : 8'h50;
            8'd12: v = 8'h3C;
            8'd13: v = 8'hBE;
            8'd14: v = 8'hFF;
            8'd15: v = 8'h03;
            8'd16: v = 8'h02;
            8'd17: v = m12 ? 8'h04 : 8'h24;
            8'd18: v = m12 ? 8'h04 : 8'h24;
            8'd26: v = m12 ? 8'h00 : 8'h01;
            8'd27: v = m12 ? 8'h00 : 8'h01;
            8'd28: v = 8'h20;
            8'd29: v = 8'h20;
            8'd30: v = 8'hFF;
            8'd31: v = 8'h01;
            8'd34: v = 8'hFF;
            8'd35: v = 8'h03;
            8'd36: v = 8'hFF;
            8'd37: v = 8'h01;
            8'd48: v = 8'h20;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/spr_table.sv =====
// ----------------------------------------------------------------------------
// spr_table: servo register table
// Single-port synchronous memory with registered read data. Per-entry
// valid bits make unwritten entries read as their power-on value.
// ----------------------------------------------------------------------------
module spr_table
    import spr_pkg::*;
#(
    parameter int TABLE_SIZE = 64,
    parameter int DEFAULT_ID = 1,
    parameter int MODEL_TYPE = 12,
    localparam int TA = $clog2(TABLE_SIZE)
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0]            mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [7:0]            mem_q;
    logic [7:0]            dflt_q;
    logic                  hit_q;
    logic [TA-1:0]         idx;

    assign idx = req.addr[TA-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd)
        begin
            mem_q  <= mem[idx];
            dflt_q <= spr_default(req.addr, 8'(DEFAULT_ID), 8'(MODEL_TYPE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_q     <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (req.rd)
            begin
                hit_q <= valid_reg[idx];
            end
        end
    end

    assign rdata = hit_q ? mem_q : dflt_q;

endmodule

// ===== rtl/spr_rxbuf.sv =====
// ----------------------------------------------------------------------------
// spr_rxbuf: received packet buffer
// Holds the bytes of the packet being framed; write data is read back
// from here when a write instruction is executed.
// ----------------------------------------------------------------------------
module spr_rxbuf
#(
    parameter int RX_DEPTH = 64,
    localparam int RA = $clog2(RX_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [RA-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [RA-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [RX_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/servo_packet_responder_unit.sv =====
// ----------------------------------------------------------------------------
// servo_packet_responder_unit: byte-serial servo with request/status replies
// Input beats carry either a received serial byte (tuser 0) or a motion
// tick (tuser 1). Output beats carry the status reply bytes, tlast on the
// checksum byte. A byte that does not complete a packet is accepted without leaving idle.
// A completed packet runs a sequencer around the register table memory:
// a write reads each data byte from the receive buffer (ST_WRD) and
// writes it to the table (ST_WWR); then, unless the packet was broadcast,
// the reply goes out at one byte per cycle for the header and checksum
// while the receiver keeps up, each read data byte being a table read
// (ST_DRD) followed by its output (ST_DOUT).
// A tick holds tready low while six table reads fetch the goal, speed and
// torque words, then two multiplies, the step and two table writes run.
// tready is high only while the sequencer is idle. A finished reply byte
// sits in the output register; a stalled receiver stalls the sequencer
// but the last byte never blocks the next input beat.
// Reset restores the default table contents, shaft position 511.0,
// step gain and clears the framing state; no clearing pass is needed.
// Configuration writes (cfg_index 0 disconnected, 1 step_gain) are taken
// at any edge with cfg_we high.
// ----------------------------------------------------------------------------
module servo_packet_responder_unit
    import spr_pkg::*;
#(
    parameter int TABLE_SIZE = 64,
    parameter int RX_DEPTH   = 64,
    parameter int MAX_READ   = 58,
    parameter int DEFAULT_ID = 1,
    parameter int MODEL_TYPE = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int RA = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);

    state_t       state_reg, state_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic [7:0]   id_reg, id_next;
    logic [7:0]   rid_reg, rid_next;
    logic         bcast_reg, bcast_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   instr_reg, instr_next;
    logic [7:0]   base_reg, base_next;
    logic [7:0]   b6_reg, b6_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [5:0]   di_reg, di_next;
    logic [7:0]   wi_reg, wi_next;
    logic [2:0]   hi_reg, hi_next;
    logic [7:0]   sum_reg, sum_next;
    logic         zero_reg, zero_next;
    logic [2:0]   tk_reg, tk_next;
    logic [7:0]   tb_reg [6];
    logic [7:0]   tb_next [6];
    logic [19:0]  st_reg, st_next;
    logic [27:0]  delta_reg, delta_next;
    logic [31:0]  pos_reg, pos_next;
    logic         disc_reg;
    logic [31:0]  gain_reg;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_data_reg, out_data_next;
    logic         out_last_reg, out_last_next;

    tbl_req_t     treq;
    logic [7:0]   tbl_rdata;
    logic         rx_we;
    logic [RA-1:0] rx_waddr, rx_raddr;
    logic [7:0]   rx_rdata;

    logic         accept, free, push, push_last;
    logic [7:0]   push_data, hdr_byte, b;
    logic [CW-1:0] pc_cur;
    logic [9:0]   pcn;
    logic [8:0]   addr9;
    logic [9:0]   spd, trq;
    logic [15:0]  spd_raw, trq_raw, goal;
    logic [51:0]  prod;
    logic signed [33:0] err, dlt;
    logic [31:0]  pos_new;

    spr_table #(
        .TABLE_SIZE (TABLE_SIZE),
        .DEFAULT_ID (DEFAULT_ID),
        .MODEL_TYPE (MODEL_TYPE)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (treq),
        .rdata (tbl_rdata)
    );

    spr_rxbuf #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rxbuf (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (s_axis_tdata),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign free          = ~out_valid_reg | m_axis_tready;
    assign b             = s_axis_tdata;
    assign pc_cur        = (32'(pc_reg) >= RX_DEPTH) ? '0 : pc_reg;
    assign pcn           = 10'(pc_cur) + 10'd1;
    assign rx_waddr      = pc_cur[RA-1:0];

    assign goal    = {tb_reg[1], tb_reg[0]};
    assign spd_raw = {tb_reg[3], tb_reg[2]};
    assign trq_raw = {tb_reg[5], tb_reg[4]};
    assign spd     = (spd_raw == 16'd0 || spd_raw > 16'(LIMIT_10BIT))
                     ? LIMIT_10BIT : spd_raw[9:0];
    assign trq     = (trq_raw > 16'(LIMIT_10BIT)) ? LIMIT_10BIT : trq_raw[9:0];
    assign prod    = 52'(st_reg) * 52'(gain_reg);

    always_comb
    begin
        err = $signed({2'b00, goal, 16'h0000}) - $signed({2'b00, pos_reg});
        dlt = $signed({6'b000000, delta_reg});
        if (err > dlt)
        begin
            err = dlt;
        end
        else if (err < -dlt)
        begin
            err = -dlt;
        end
        pos_new = pos_reg + err[31:0];
    end

    always_comb
    begin
        unique case (hi_reg)
            3'd0, 3'd1: hdr_byte = SYNC_BYTE;
            3'd2:       hdr_byte = rid_reg;
            3'd3:       hdr_byte = 8'(cnt_reg) + 8'd2;
            default:    hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        id_next    = id_reg;
        rid_next   = rid_reg;
        bcast_next = bcast_reg;
        len_next   = len_reg;
        instr_next = instr_reg;
        base_next  = base_reg;
        b6_next    = b6_reg;
        cnt_next   = cnt_reg;
        di_next    = di_reg;
        wi_next    = wi_reg;
        hi_next    = hi_reg;
        sum_next   = sum_reg;
        zero_next  = zero_reg;
        tk_next    = tk_reg;
        tb_next    = tb_reg;
        st_next    = st_reg;
        delta_next = delta_reg;
        pos_next   = pos_reg;
        treq       = '0;
        rx_we      = 1'b0;
        rx_raddr   = RA'(32'd6 + 32'(wi_reg));
        push       = 1'b0;
        push_data  = 8'h00;
        push_last  = 1'b0;
        addr9      = 9'(base_reg) + 9'(wi_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tuser)
                begin
                    tk_next    = '0;
                    state_next = ST_TRD;
                end
                else if (accept && !disc_reg)
                begin
                    rx_we   = 1'b1;
                    pc_next = CW'(pcn);
                    if (pcn <= 10'd2)
                    begin
                        if (b != SYNC_BYTE)
                        begin
                            pc_next = '0;
                        end
                    end
                    else if (pcn == 10'd3)
                    begin
                        bcast_next = (b == BROADCAST_ID);
                        if (b != id_reg && b != BROADCAST_ID)
                        begin
                            pc_next = '0;
                        end
                    end
                    else if (pcn == 10'd4)
                    begin
                        len_next = b;
                        if (b < 8'd2 || 32'(b) + 4 > RX_DEPTH)
                        begin
                            pc_next = '0;
                        end
                    end
                    else
                    begin
                        if (pcn == 10'd5)
                        begin
                            instr_next = b;
                        end
                        if (pcn == 10'd6)
                        begin
                            base_next = b;
                        end
                        if (pcn == 10'd7)
                        begin
                            b6_next = b;
                        end
                        if (pcn == 10'(len_reg) + 10'd4)
                        begin
                            pc_next    = '0;
                            state_next = ST_EXEC;
                        end
                    end
                end
            end

            ST_EXEC:
            begin
                rid_next = id_reg;
                hi_next  = '0;
                sum_next = '0;
                wi_next  = '0;
                di_next  = '0;
                cnt_next = '0;
                if (instr_reg == INSTR_READ && len_reg >= 8'd3)
                begin
                    cnt_next = (32'(b6_reg) > MAX_READ) ? 6'(MAX_READ) : b6_reg[5:0];
                end
                if (instr_reg == INSTR_WRITE && len_reg > 8'd3)
                begin
                    state_next = ST_WRD;
                end
                else if (!bcast_reg)
                begin
                    state_next = ST_HDR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_WRD:
            begin
                state_next = ST_WWR;
            end

            ST_WWR:
            begin
                // skip address 0 and anything past the table
                if (addr9 != 9'd0 && 32'(addr9) < TABLE_SIZE)
                begin
                    treq.wr    = 1'b1;
                    treq.addr  = addr9[7:0];
                    treq.wdata = rx_rdata;
                    if (addr9 == 9'(ADDR_ID))
                    begin
                        id_next = rx_rdata;
                    end
                end
                wi_next = wi_reg + 8'd1;
                if (wi_reg + 8'd1 == len_reg - 8'd3)
                begin
                    state_next = bcast_reg ? ST_IDLE : ST_HDR;
                end
                else
                begin
                    state_next = ST_WRD;
                end
            end

            ST_HDR:
            begin
                if (free)
                begin
                    push      = 1'b1;
                    push_data = hdr_byte;
                    hi_next   = hi_reg + 3'd1;
                    if (hi_reg >= 3'd2)
                    begin
                        sum_next = sum_reg + hdr_byte;
                    end
                    if (hi_reg == 3'd4)
                    begin
                        state_next = (cnt_reg == 6'd0) ? ST_CHK : ST_DRD;
                    end
                end
            end

            ST_DRD:
            begin
                addr9      = 9'(base_reg) + 9'(di_reg);
                treq.rd    = 1'b1;
                treq.addr  = addr9[7:0];
                zero_next  = (addr9 == 9'd0) || (32'(addr9) >= TABLE_SIZE);
                state_next = ST_DOUT;
            end

            ST_DOUT:
            begin
                if (free)
                begin
                    push      = 1'b1;
                    push_data = zero_reg ? 8'h00 : tbl_rdata;
                    sum_next  = sum_reg + push_data;
                    di_next   = di_reg + 6'd1;
                    state_next = (di_reg + 6'd1 == cnt_reg) ? ST_CHK : ST_DRD;
                end
            end

            ST_CHK:
            begin
                if (free)
                begin
                    push       = 1'b1;
                    push_data  = ~sum_reg;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_TRD:
            begin
                // read goal, speed and torque words one byte a cycle
                if (tk_reg < 3'd6)
                begin
                    treq.rd   = 1'b1;
                    treq.addr = ADDR_GOAL + 8'(tk_reg);
                end
                if (tk_reg != 3'd0)
                begin
                    tb_next[tk_reg - 3'd1] = tbl_rdata;
                end
                tk_next = tk_reg + 3'd1;
                if (tk_reg == 3'd6)
                begin
                    state_next = ST_TMUL;
                end
            end

            ST_TMUL:
            begin
                st_next    = 20'(spd) * 20'(trq);
                state_next = ST_TGAIN;
            end

            ST_TGAIN:
            begin
                delta_next = prod[51:24];
                state_next = ST_TSTEP;
            end

            ST_TSTEP:
            begin
                pos_next   = pos_new;
                tk_next    = '0;
                state_next = ST_TPRES;
            end

            ST_TPRES:
            begin
                treq.wr = 1'b1;
                if (tk_reg == 3'd0)
                begin
                    treq.addr  = ADDR_PRESENT;
                    treq.wdata = pos_reg[23:16];
                    tk_next    = 3'd1;
                end
                else
                begin
                    treq.addr  = ADDR_PRESENT + 8'd1;
                    treq.wdata = pos_reg[31:24];
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
            out_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            id_reg        <= 8'(DEFAULT_ID);
            pos_reg       <= POS_RESET;
            disc_reg      <= 1'b0;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            id_reg        <= id_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DISCONNECTED: disc_reg <= cfg_wdata[0];
                    CFG_STEP_GAIN:    gain_reg <= cfg_wdata;
                    default:          gain_reg <= gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rid_reg      <= rid_next;
        bcast_reg    <= bcast_next;
        len_reg      <= len_next;
        instr_reg    <= instr_next;
        base_reg     <= base_next;
        b6_reg       <= b6_next;
        cnt_reg      <= cnt_next;
        di_reg       <= di_next;
        wi_reg       <= wi_next;
        hi_reg       <= hi_next;
        sum_reg      <= sum_next;
        zero_reg     <= zero_next;
        tk_reg       <= tk_next;
        tb_reg       <= tb_next;
        st_reg       <= st_next;
        delta_reg    <= delta_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pc_reg) < RX_DEPTH)
        else $error("packet count out of range");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRD || state_reg == ST_DOUT) |-> (di_reg < cnt_reg))
        else $error("read data index past count");

    a_chk_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK && free) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("checksum beat not marked last");

endmodule
